@@ sv/i2ra_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the radix ASCII converter.
package i2ra_pkg;

   localparam int ValueBits  = 31;
   localparam int DigitBits  = 6;
   localparam int CharBits   = 7;
   localparam int CellCount  = ValueBits;
   localparam int CountBits  = $clog2(CellCount + 1);
   localparam int StepBits   = $clog2(ValueBits);

   localparam logic [DigitBits-1:0] RadixReset = DigitBits'(10);
   localparam logic [DigitBits-1:0] RadixMin   = DigitBits'(2);
   localparam logic [DigitBits-1:0] RadixMax   = DigitBits'(36);
   localparam logic [DigitBits-1:0] DecDigits  = DigitBits'(10);
   localparam logic [CharBits-1:0]  CharZero   = CharBits'(48);
   localparam logic [CharBits-1:0]  CharA      = CharBits'(65);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

   function automatic logic [DigitBits-1:0] clamp_radix(input logic [DigitBits-1:0] r);
      logic [DigitBits-1:0] res;
      res = r;
      if (r < RadixMin) begin
         res = RadixMin;
      end else if (r > RadixMax) begin
         res = RadixMax;
      end
      return res;
   endfunction

   function automatic logic [CharBits-1:0] digit_to_ascii(input logic [DigitBits-1:0] d);
      logic [CharBits-1:0] res;
      if (d < DecDigits) begin
         res = CharZero + CharBits'(d);
      end else begin
         res = CharA + CharBits'(d - DecDigits);
      end
      return res;
   endfunction

endpackage

@@ sv/i2ra_cell.sv @@
`timescale 1ns / 1ps
// One digit cell of the stack chain; shifts toward the tail on push, toward the head on pop.
module i2ra_cell (
   input  logic                             clock,
   input  i2ra_pkg::stack_ctl_type          ctl,
   input  logic [i2ra_pkg::DigitBits-1:0]   prev_digit,
   input  logic [i2ra_pkg::DigitBits-1:0]   next_digit,
   output logic [i2ra_pkg::DigitBits-1:0]   digit
);

   logic [i2ra_pkg::DigitBits-1:0] digit_ff;
   logic [i2ra_pkg::DigitBits-1:0] digit_in;

   always_comb begin
      digit_in = digit_ff;
      if (ctl.push) begin
         digit_in = prev_digit;
      end else if (ctl.pop) begin
         digit_in = next_digit;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

@@ sv/i2ra_divider.sv @@
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle.
module i2ra_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [i2ra_pkg::ValueBits-1:0]   dividend,
   input  logic [i2ra_pkg::DigitBits-1:0]   divisor,
   output logic                             done,
   output logic [i2ra_pkg::ValueBits-1:0]   quotient,
   output logic [i2ra_pkg::DigitBits-1:0]   remainder
);

   logic [i2ra_pkg::ValueBits-1:0] quo_ff, quo_in;
   logic [i2ra_pkg::DigitBits-1:0] rem_ff, rem_in;
   logic [i2ra_pkg::DigitBits-1:0] dvs_ff, dvs_in;
   logic [i2ra_pkg::StepBits-1:0]  cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [i2ra_pkg::DigitBits:0]   trial;
   logic                           fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[i2ra_pkg::ValueBits-1]};
      fits    = trial >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = i2ra_pkg::StepBits'(i2ra_pkg::ValueBits - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits in a digit.
         rem_in = fits ? i2ra_pkg::DigitBits'(trial - {1'b0, dvs_ff})
                       : i2ra_pkg::DigitBits'(trial);
         quo_in = {quo_ff[i2ra_pkg::ValueBits-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ sv/integer_to_radix_ascii_top.sv @@
`timescale 1ns / 1ps
// Each digit costs one pass through the bit-serial divider.
// A value with D digits is accepted, divided once per digit, then emits D characters,
// one per cycle when rsp_ready stays high; the next transaction is taken after the last.
// Only one transaction is in flight at a time, as the single shared divider serves it.
// Reset: synchronous, active high; clears control state and sets the radix to ten.
module integer_to_radix_ascii_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [i2ra_pkg::ValueBits-1:0]   req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [i2ra_pkg::CharBits-1:0]    rsp_digit_char,
   output logic                             rsp_last,
   input  logic                             csr_we,
   input  logic [i2ra_pkg::DigitBits-1:0]   csr_wdata
);

   i2ra_pkg::state_type              state_ff, state_in;
   logic [i2ra_pkg::DigitBits-1:0]   radix_ff, radix_in;
   logic [i2ra_pkg::CountBits-1:0]   count_ff, count_in;
   i2ra_pkg::stack_ctl_type          stk_ctl;
   logic                             div_start;
   logic [i2ra_pkg::ValueBits-1:0]   div_dividend;
   logic                             div_done;
   logic [i2ra_pkg::ValueBits-1:0]   div_quotient;
   logic [i2ra_pkg::DigitBits-1:0]   div_remainder;
   logic [i2ra_pkg::DigitBits-1:0]   cell_digit [i2ra_pkg::CellCount];
   logic                             req_fire;
   logic                             rsp_fire;

   assign radix_in = csr_we ? csr_wdata : radix_ff;
   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      div_start    = 1'b0;
      div_dividend = req_value;
      stk_ctl      = '0;
      unique case (state_ff)
         i2ra_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               div_start = 1'b1;
               state_in  = i2ra_pkg::ST_DIV;
            end
         end
         i2ra_pkg::ST_DIV: begin
            if (div_done) begin
               stk_ctl.push = 1'b1;
               count_in     = count_ff + 1'b1;
               // Keep dividing until the quotient runs out; zero still yields one digit.
               if (div_quotient == '0) begin
                  state_in = i2ra_pkg::ST_EMIT;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = div_quotient;
               end
            end
         end
         i2ra_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               stk_ctl.pop = 1'b1;
               count_in    = count_ff - 1'b1;
               if (count_ff == i2ra_pkg::CountBits'(1)) begin
                  state_in = i2ra_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = i2ra_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= i2ra_pkg::ST_IDLE;
         radix_ff <= i2ra_pkg::RadixReset;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         radix_ff <= radix_in;
         count_ff <= count_in;
      end
   end

   i2ra_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (i2ra_pkg::clamp_radix(radix_ff)),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // Digits arrive least significant first, so the chain works as a stack.
   for (genvar i = 0; i < i2ra_pkg::CellCount; i++) begin : g_cell
      logic [i2ra_pkg::DigitBits-1:0] prev_digit;
      logic [i2ra_pkg::DigitBits-1:0] next_digit;
      if (i == 0) begin : g_head
         assign prev_digit = div_remainder;
      end else begin : g_body
         assign prev_digit = cell_digit[i-1];
      end
      if (i == i2ra_pkg::CellCount - 1) begin : g_tail
         assign next_digit = '0;
      end else begin : g_inner
         assign next_digit = cell_digit[i+1];
      end
      i2ra_cell u_cell (
         .clock      (clock),
         .ctl        (stk_ctl),
         .prev_digit (prev_digit),
         .next_digit (next_digit),
         .digit      (cell_digit[i])
      );
   end

   assign rsp_digit_char = i2ra_pkg::digit_to_ascii(cell_digit[0]);
   assign rsp_last       = (count_ff == i2ra_pkg::CountBits'(1));

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= i2ra_pkg::CountBits'(i2ra_pkg::CellCount))
      else $error("digit stack overflow");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == i2ra_pkg::ST_IDLE) |-> (count_ff == '0))
      else $error("digits left over while idle");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_last) |=> (state_ff == i2ra_pkg::ST_IDLE))
      else $error("block did not return to idle after the last character");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (count_ff != '0))
      else $error("character offered from an empty stack");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == i2ra_pkg::ST_DIV))
      else $error("accepted transaction did not start a division");

endmodule

@@ tb/sv/i2ra_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts the character stream of the radix converter and compares it.
module i2ra_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [i2ra_pkg::ValueBits-1:0]      req_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [i2ra_pkg::CharBits-1:0]       rsp_digit_char,
   input  logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [i2ra_pkg::DigitBits-1:0]      csr_wdata,
   output int                                  error_count,
   output int                                  pending_count
);

   typedef struct packed {
      logic [i2ra_pkg::CharBits-1:0] digit_char;
      logic                          last;
   } char_item_type;

   logic [i2ra_pkg::DigitBits-1:0] radix_reg;
   char_item_type                  char_queue[$];

   function automatic logic [i2ra_pkg::CharBits-1:0] char_of(input int d);
      if (d < 10) return i2ra_pkg::CharBits'(48 + d);
      return i2ra_pkg::CharBits'(65 + d - 10);
   endfunction

   task automatic predict_chars(input logic [i2ra_pkg::ValueBits-1:0] v);
      int            base;
      longint        rest;
      int            digits[$];
      char_item_type c;
      base = radix_reg;
      if (base < 2) base = 2;
      if (base > 36) base = 36;
      rest = v;
      if (rest == 0) digits.push_front(0);
      while (rest > 0) begin
         digits.push_front(int'(rest % base));
         rest = rest / base;
      end
      foreach (digits[k]) begin
         c.digit_char = char_of(digits[k]);
         c.last       = (k == digits.size() - 1);
         char_queue.push_back(c);
      end
   endtask

   assign pending_count = char_queue.size();

   always @(posedge clock) begin
      char_item_type want;
      if (reset) begin
         radix_reg   <= i2ra_pkg::DigitBits'(10);
         error_count <= 0;
         char_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (char_queue.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected character %0d last %0b", rsp_digit_char, rsp_last);
               error_count <= error_count + 1;
            end else begin
               want = char_queue.pop_front();
               if (want.digit_char !== rsp_digit_char || want.last !== rsp_last) begin
                  if (error_count < 10)
                     $display("expected char %0d last %0b, got char %0d last %0b",
                              want.digit_char, want.last, rsp_digit_char, rsp_last);
                  error_count <= error_count + 1;
               end
            end
         end
         // Radix writes only happen while idle, so order against requests does not matter.
         if (req_valid && req_ready) predict_chars(req_value);
         if (csr_we) radix_reg <= csr_wdata;
      end
   end
endmodule

@@ tb/sv/integer_to_radix_ascii_top_tb.sv @@
`timescale 1ns / 1ps
// Top of the radix converter testbench: clock, reset, stimulus and verdict.
module integer_to_radix_ascii_top_tb;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [i2ra_pkg::ValueBits-1:0] req_value = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [i2ra_pkg::CharBits-1:0]  rsp_digit_char;
   logic                           rsp_last;
   logic                           csr_we = 1'b0;
   logic [i2ra_pkg::DigitBits-1:0] csr_wdata = '0;
   int                             error_count;
   int                             pending_count;
   bit                             hold_off = 1'b0;

   integer_to_radix_ascii_top u_dut (.*);
   i2ra_checker u_chk (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("integer_to_radix_ascii_top: mismatch");
      $finish;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Receiver: random stalls, plus one long hold-off while the next requests wait.
   initial begin
      int n;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_off = 1'b0;
         end
         n = gap_len();
         if (n != 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_value(input logic [i2ra_pkg::ValueBits-1:0] v);
      int n;
      n = gap_len();
      repeat (n) @(posedge clock);
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      req_valid <= 1'b0;
      // The block takes no new transaction right after one, so this costs nothing.
      @(posedge clock);
   endtask

   task automatic write_radix(input logic [i2ra_pkg::DigitBits-1:0] r);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= r;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [i2ra_pkg::ValueBits-1:0] random_value();
      unique case ($urandom_range(0, 3))
         0: return i2ra_pkg::ValueBits'($urandom_range(0, 40));
         1: return i2ra_pkg::ValueBits'($urandom_range(0, 65535));
         2: return i2ra_pkg::ValueBits'(31'h7fff_ffff - $urandom_range(0, 100));
         default: return i2ra_pkg::ValueBits'($urandom);
      endcase
   endfunction

   initial begin
      logic [i2ra_pkg::DigitBits-1:0] radix_set[8] =
         '{6'd0, 6'd1, 6'd2, 6'd36, 6'd63, 6'd37, 6'd16, 6'd7};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Reset radix of ten: zero, one, the extremes, a few alternating patterns, nine and ten.
      send_value('0);
      send_value(31'd1);
      send_value(31'h7fff_ffff);
      send_value(31'h5555_5555);
      send_value(31'h2aaa_aaaa);
      send_value(31'd9);
      send_value(31'd10);
      foreach (radix_set[i]) begin
         write_radix(radix_set[i]);
         send_value('0);
         send_value(31'h7fff_ffff);
         send_value(31'd35);
      end
      write_radix(6'd36);
      hold_off = 1'b1;
      repeat (8) send_value(31'd1295);
      for (int i = 0; i < 400; i++) begin
         if (i % 50 == 0) write_radix(i2ra_pkg::DigitBits'($urandom));
         send_value(random_value());
      end
      while (pending_count != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (error_count == 0) begin
         $display("integer_to_radix_ascii_top: match");
      end else begin
         $display("integer_to_radix_ascii_top: mismatch");
      end
      $finish;
   end
endmodule
